FILE: rtl/dcr_pkg.sv
package dcr_pkg;

  localparam int POS_W      = 32;
  localparam int MASS_W     = 31;
  localparam int STAT_W     = 2;
  localparam int GUARD_BITS = 16;

  // digit-serial units, one bit per stage
  localparam int SQ_N = 33;               // root of a 66-bit sum of squares
  localparam int OD_N = 33;               // separation offset, at most the radius sum
  localparam int TD_N = 33 + GUARD_BITS;  // projection with guard bits
  localparam int VD_N = 35;               // velocity change

  // stage map
  localparam int ST_SQ0 = 3;
  localparam int ST_OFF = ST_SQ0 + SQ_N;
  localparam int ST_OD0 = ST_OFF + 1;
  localparam int ST_SAT = ST_OD0 + OD_N;
  localparam int ST_E   = ST_SAT + 1;
  localparam int ST_MUL = ST_E + 1;
  localparam int ST_DOT = ST_MUL + 1;
  localparam int ST_PP  = ST_DOT + 1;
  localparam int ST_NUM = ST_PP + 1;
  localparam int ST_TD0 = ST_NUM + 1;
  localparam int ST_PP2 = ST_TD0 + TD_N;
  localparam int ST_N   = ST_PP2 + 1;
  localparam int ST_RND = ST_N + 1;
  localparam int ST_VD0 = ST_RND + 1;
  localparam int ST_VEL = ST_VD0 + VD_N;
  localparam int N_ST   = ST_VEL + 1;

  localparam logic [STAT_W-1:0] STAT_NONE  = 2'd0;
  localparam logic [STAT_W-1:0] STAT_HIT   = 2'd1;
  localparam logic [STAT_W-1:0] STAT_COINC = 2'd2;

  typedef struct packed {
    logic signed [31:0] xa;
    logic signed [31:0] ya;
    logic signed [31:0] xb;
    logic signed [31:0] yb;
    logic signed [31:0] vxa;
    logic signed [31:0] vya;
    logic signed [31:0] vxb;
    logic signed [31:0] vyb;
    logic [30:0]        ma;
    logic [30:0]        mb;
    logic [31:0]        msum;
    logic [31:0]        rsum;
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic               contact;
    logic               coinc;
    logic signed [31:0] nxb;
    logic signed [31:0] nyb;
    logic [32:0]        exm;
    logic [32:0]        eym;
    logic               ex_neg;
    logic               ey_neg;
    logic               dneg;
    logic               vel_ok;
  } dcr_pass_t;

  function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
    logic signed [31:0] r;
    if (v > $signed(40'h00_7fff_ffff)) begin
      r = 32'sh7fff_ffff;
    end else if (v < $signed(40'hff_8000_0000)) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic [32:0] mag33(input logic signed [32:0] v);
    logic [32:0] r;
    if (v[32]) begin
      r = ~v + 33'd1;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

FILE: rtl/dcr_in_if.sv
interface dcr_in_if import dcr_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [POS_W-1:0]  pos_x_a;
  logic signed [POS_W-1:0]  pos_y_a;
  logic signed [POS_W-1:0]  vel_x_a;
  logic signed [POS_W-1:0]  vel_y_a;
  logic [MASS_W-1:0]        mass_a;
  logic [MASS_W-1:0]        radius_a;
  logic signed [POS_W-1:0]  pos_x_b;
  logic signed [POS_W-1:0]  pos_y_b;
  logic signed [POS_W-1:0]  vel_x_b;
  logic signed [POS_W-1:0]  vel_y_b;
  logic [MASS_W-1:0]        mass_b;
  logic [MASS_W-1:0]        radius_b;

  modport source (
    output valid, pos_x_a, pos_y_a, vel_x_a, vel_y_a, mass_a, radius_a,
           pos_x_b, pos_y_b, vel_x_b, vel_y_b, mass_b, radius_b,
    input  ready
  );
  modport sink (
    input  valid, pos_x_a, pos_y_a, vel_x_a, vel_y_a, mass_a, radius_a,
           pos_x_b, pos_y_b, vel_x_b, vel_y_b, mass_b, radius_b,
    output ready
  );
endinterface

FILE: rtl/dcr_out_if.sv
interface dcr_out_if import dcr_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [STAT_W-1:0]        status;
  logic signed [POS_W-1:0]  new_pos_x_b;
  logic signed [POS_W-1:0]  new_pos_y_b;
  logic signed [POS_W-1:0]  new_vel_x_a;
  logic signed [POS_W-1:0]  new_vel_y_a;
  logic signed [POS_W-1:0]  new_vel_x_b;
  logic signed [POS_W-1:0]  new_vel_y_b;

  modport source (
    output valid, status, new_pos_x_b, new_pos_y_b,
           new_vel_x_a, new_vel_y_a, new_vel_x_b, new_vel_y_b,
    input  ready
  );
  modport sink (
    input  valid, status, new_pos_x_b, new_pos_y_b,
           new_vel_x_a, new_vel_y_a, new_vel_x_b, new_vel_y_b,
    output ready
  );
endinterface

FILE: rtl/disc_collision_resolve.sv
// Disc pair contact and elastic response. One pair is taken per clock and one
// result leaves per clock, unless the output stalls. The pipe's depth comes
// from the bit-per-stage units in it: a 33-step square root of the squared
// center distance, a 33-step divider for the separation offset, a 49-step
// divider for the projection onto the contact normal and a 35-step divider
// for the mass-weighted velocity change. The whole pipe holds while the
// output beat waits, unless its last stage is empty, so bubbles are squeezed
// out during a stall. No reset sweep: the block is ready right after reset.
module disc_collision_resolve import dcr_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  dcr_in_if.sink   in_ch,
  dcr_out_if.source out_ch
);

  logic              adv;
  logic [N_ST-1:0]   v_r;
  dcr_pass_t         p_r   [N_ST];
  dcr_pass_t         p_nxt [N_ST];
  logic              out_valid_r;

  assign adv = !v_r[N_ST-1] || !out_valid_r || out_ch.ready;
  assign in_ch.ready = adv;

  // ---------------- front: squares and contact test ----------------
  logic [65:0] s1_dx2_r, s1_dy2_r;
  logic [63:0] s1_rr_r;
  logic [65:0] dist2_r;
  logic [65:0] dist2;

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_dx2_r <= mag33(p_r[0].dx) * mag33(p_r[0].dx);
      s1_dy2_r <= mag33(p_r[0].dy) * mag33(p_r[0].dy);
      s1_rr_r  <= p_r[0].rsum * p_r[0].rsum;
      dist2_r  <= dist2;
    end
  end

  assign dist2 = s1_dx2_r + s1_dy2_r;

  // ---------------- integer square root ----------------
  logic [65:0] sq_rad_r  [SQ_N];
  logic [35:0] sq_rem_r  [SQ_N];
  logic [32:0] sq_root_r [SQ_N];

  for (genvar i = 0; i < SQ_N; i++) begin : g_sq
    logic [65:0] rad_in;
    logic [35:0] rem_in;
    logic [32:0] root_in;
    logic [35:0] r2;
    logic [35:0] trial;
    if (i == 0) begin : g_first
      assign rad_in  = dist2_r;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_rest
      assign rad_in  = sq_rad_r[i-1];
      assign rem_in  = sq_rem_r[i-1];
      assign root_in = sq_root_r[i-1];
    end
    assign r2    = {rem_in[33:0], rad_in[65:64]};
    assign trial = {1'b0, root_in, 2'b01};
    always_ff @(posedge clk) begin
      if (adv) begin
        sq_rad_r[i] <= {rad_in[63:0], 2'b00};
        if (r2 >= trial) begin
          sq_rem_r[i]  <= r2 - trial;
          sq_root_r[i] <= {root_in[31:0], 1'b1};
        end else begin
          sq_rem_r[i]  <= r2;
          sq_root_r[i] <= {root_in[31:0], 1'b0};
        end
      end
    end
  end

  // ---------------- separation offset ----------------
  logic [33:0]     on_rem_r [2];
  logic [OD_N-1:0] on_lq_r  [2];
  logic [32:0]     on_d_r;
  logic [65:0]     on_num   [2];

  assign on_num[0] = mag33(p_r[ST_OFF-1].dx) * p_r[ST_OFF-1].rsum
                   + {33'd0, sq_root_r[SQ_N-1][32:1]};
  assign on_num[1] = mag33(p_r[ST_OFF-1].dy) * p_r[ST_OFF-1].rsum
                   + {33'd0, sq_root_r[SQ_N-1][32:1]};

  always_ff @(posedge clk) begin
    if (adv) begin
      on_d_r <= sq_root_r[SQ_N-1];
      for (int k = 0; k < 2; k++) begin
        on_rem_r[k] <= {1'b0, on_num[k][65:33]};
        on_lq_r[k]  <= on_num[k][32:0];
      end
    end
  end

  logic [33:0]     od_rem_r [OD_N][2];
  logic [OD_N-1:0] od_lq_r  [OD_N][2];
  logic [32:0]     od_d_r   [OD_N];

  for (genvar i = 0; i < OD_N; i++) begin : g_od
    logic [32:0] d_in;
    if (i == 0) begin : g_first
      assign d_in = on_d_r;
    end else begin : g_rest
      assign d_in = od_d_r[i-1];
    end
    always_ff @(posedge clk) begin
      if (adv) od_d_r[i] <= d_in;
    end
    for (genvar k = 0; k < 2; k++) begin : g_lane
      logic [33:0]     rem_in;
      logic [OD_N-1:0] lq_in;
      logic [33:0]     r2;
      logic            ge;
      if (i == 0) begin : g_first
        assign rem_in = on_rem_r[k];
        assign lq_in  = on_lq_r[k];
      end else begin : g_rest
        assign rem_in = od_rem_r[i-1][k];
        assign lq_in  = od_lq_r[i-1][k];
      end
      assign r2 = {rem_in[32:0], lq_in[OD_N-1]};
      assign ge = r2 >= {1'b0, d_in};
      always_ff @(posedge clk) begin
        if (adv) begin
          od_rem_r[i][k] <= ge ? r2 - {1'b0, d_in} : r2;
          od_lq_r[i][k]  <= {lq_in[OD_N-2:0], ge};
        end
      end
    end
  end

  logic [39:0] sep_x, sep_y;
  logic [39:0] ox_ext, oy_ext;
  assign ox_ext = {7'd0, od_lq_r[OD_N-1][0]};
  assign oy_ext = {7'd0, od_lq_r[OD_N-1][1]};
  assign sep_x = {{8{p_r[ST_SAT-1].xa[31]}}, p_r[ST_SAT-1].xa}
               + (p_r[ST_SAT-1].dx[32] ? -ox_ext : ox_ext);
  assign sep_y = {{8{p_r[ST_SAT-1].ya[31]}}, p_r[ST_SAT-1].ya}
               + (p_r[ST_SAT-1].dy[32] ? -oy_ext : oy_ext);

  // ---------------- contact normal and projections ----------------
  logic signed [32:0] ex, ey, dvx, dvy;
  logic signed [32:0] e_ex_r, e_ey_r, e_dvx_r, e_dvy_r;

  assign ex  = {p_r[ST_E-1].xa[31], p_r[ST_E-1].xa} - {p_r[ST_E-1].nxb[31], p_r[ST_E-1].nxb};
  assign ey  = {p_r[ST_E-1].ya[31], p_r[ST_E-1].ya} - {p_r[ST_E-1].nyb[31], p_r[ST_E-1].nyb};
  assign dvx = {p_r[ST_E-1].vxa[31], p_r[ST_E-1].vxa}
             - {p_r[ST_E-1].vxb[31], p_r[ST_E-1].vxb};
  assign dvy = {p_r[ST_E-1].vya[31], p_r[ST_E-1].vya}
             - {p_r[ST_E-1].vyb[31], p_r[ST_E-1].vyb};

  logic [65:0]        m_xx_r, m_yy_r;
  logic signed [65:0] m_dx_r, m_dy_r;
  logic [65:0]        len2;
  logic signed [66:0] dm;
  logic [66:0]        dm_mag;
  logic [65:0]        dot_len_r, dot_mag_r;
  logic [65:0]        pp_r [2][2];
  logic [65:0]        pp_len_r;
  logic [98:0]        num99 [2];
  logic [66:0]        tn_rem_r [2];
  logic [TD_N-1:0]    tn_lq_r  [2];
  logic [65:0]        tn_len_r;

  assign len2   = m_xx_r + m_yy_r;
  assign dm     = {m_dx_r[65], m_dx_r} + {m_dy_r[65], m_dy_r};
  assign dm_mag = dm[66] ? ~dm + 67'd1 : dm;
  assign num99[0] = {33'd0, pp_r[0][0]} + {pp_r[0][1], 33'd0};
  assign num99[1] = {33'd0, pp_r[1][0]} + {pp_r[1][1], 33'd0};

  always_ff @(posedge clk) begin
    if (adv) begin
      e_ex_r    <= ex;
      e_ey_r    <= ey;
      e_dvx_r   <= dvx;
      e_dvy_r   <= dvy;
      m_xx_r    <= mag33(e_ex_r) * mag33(e_ex_r);
      m_yy_r    <= mag33(e_ey_r) * mag33(e_ey_r);
      m_dx_r    <= e_dvx_r * e_ex_r;
      m_dy_r    <= e_dvy_r * e_ey_r;
      dot_len_r <= len2;
      dot_mag_r <= dm_mag[65:0];
      pp_r[0][0] <= dot_mag_r[32:0]  * p_r[ST_PP-1].exm;
      pp_r[0][1] <= dot_mag_r[65:33] * p_r[ST_PP-1].exm;
      pp_r[1][0] <= dot_mag_r[32:0]  * p_r[ST_PP-1].eym;
      pp_r[1][1] <= dot_mag_r[65:33] * p_r[ST_PP-1].eym;
      pp_len_r   <= dot_len_r;
      tn_len_r   <= pp_len_r;
      for (int k = 0; k < 2; k++) begin
        tn_rem_r[k] <= {1'b0, num99[k][98:33]};
        tn_lq_r[k]  <= {num99[k][32:0], {GUARD_BITS{1'b0}}};
      end
    end
  end

  logic [66:0]     td_rem_r [TD_N][2];
  logic [TD_N-1:0] td_lq_r  [TD_N][2];
  logic [65:0]     td_len_r [TD_N];

  for (genvar i = 0; i < TD_N; i++) begin : g_td
    logic [65:0] len_in;
    if (i == 0) begin : g_first
      assign len_in = tn_len_r;
    end else begin : g_rest
      assign len_in = td_len_r[i-1];
    end
    always_ff @(posedge clk) begin
      if (adv) td_len_r[i] <= len_in;
    end
    for (genvar k = 0; k < 2; k++) begin : g_lane
      logic [66:0]     rem_in;
      logic [TD_N-1:0] lq_in;
      logic [66:0]     r2;
      logic            ge;
      if (i == 0) begin : g_first
        assign rem_in = tn_rem_r[k];
        assign lq_in  = tn_lq_r[k];
      end else begin : g_rest
        assign rem_in = td_rem_r[i-1][k];
        assign lq_in  = td_lq_r[i-1][k];
      end
      assign r2 = {rem_in[65:0], lq_in[TD_N-1]};
      assign ge = r2 >= {1'b0, len_in};
      always_ff @(posedge clk) begin
        if (adv) begin
          td_rem_r[i][k] <= ge ? r2 - {1'b0, len_in} : r2;
          td_lq_r[i][k]  <= {lq_in[TD_N-2:0], ge};
        end
      end
    end
  end

  // ---------------- mass weighting ----------------
  // lanes: 0 x of disc a, 1 x of disc b, 2 y of disc a, 3 y of disc b
  logic [56:0] q_lo_r [4];
  logic [55:0] q_hi_r [4];
  logic [80:0] n_r    [4];
  logic [81:0] rnd    [4];
  logic [32:0] vn_rem_r [4];
  logic [VD_N-1:0] vn_lq_r [4];
  logic [31:0] m2a, m2b;

  assign m2a = {p_r[ST_PP2-1].ma, 1'b0};
  assign m2b = {p_r[ST_PP2-1].mb, 1'b0};

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      rnd[j] = {1'b0, n_r[j]} + {35'd0, p_r[ST_RND-1].msum, 15'd0};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < 4; j++) begin
        q_lo_r[j] <= td_lq_r[TD_N-1][j/2][24:0]  * (j % 2 == 1 ? m2a : m2b);
        q_hi_r[j] <= td_lq_r[TD_N-1][j/2][48:25] * (j % 2 == 1 ? m2a : m2b);
        n_r[j]    <= {24'd0, q_lo_r[j]} + {q_hi_r[j], 25'd0};
        vn_rem_r[j] <= {2'b00, rnd[j][81:51]};
        vn_lq_r[j]  <= rnd[j][50:16];
      end
    end
  end

  logic [32:0]     vd_rem_r [VD_N][4];
  logic [VD_N-1:0] vd_lq_r  [VD_N][4];

  for (genvar i = 0; i < VD_N; i++) begin : g_vd
    for (genvar j = 0; j < 4; j++) begin : g_lane
      logic [32:0]     rem_in;
      logic [VD_N-1:0] lq_in;
      logic [32:0]     r2;
      logic            ge;
      if (i == 0) begin : g_first
        assign rem_in = vn_rem_r[j];
        assign lq_in  = vn_lq_r[j];
      end else begin : g_rest
        assign rem_in = vd_rem_r[i-1][j];
        assign lq_in  = vd_lq_r[i-1][j];
      end
      assign r2 = {rem_in[31:0], lq_in[VD_N-1]};
      assign ge = r2 >= {1'b0, p_r[ST_VD0+i-1].msum};
      always_ff @(posedge clk) begin
        if (adv) begin
          vd_rem_r[i][j] <= ge ? r2 - {1'b0, p_r[ST_VD0+i-1].msum} : r2;
          vd_lq_r[i][j]  <= {lq_in[VD_N-2:0], ge};
        end
      end
    end
  end

  logic signed [31:0] vel_r [4];
  logic signed [31:0] vel_nxt [4];

  always_comb begin
    logic [39:0] dd;
    logic [39:0] sd;
    logic [39:0] base;
    logic        sneg;
    dcr_pass_t   q;
    q = p_r[ST_VEL-1];
    for (int j = 0; j < 4; j++) begin
      dd = {5'd0, vd_lq_r[VD_N-1][j]};
      sneg = q.dneg ^ (j / 2 == 1 ? q.ey_neg : q.ex_neg);
      sd = sneg ? -dd : dd;
      case (j)
        0:       base = {{8{q.vxa[31]}}, q.vxa};
        1:       base = {{8{q.vxb[31]}}, q.vxb};
        2:       base = {{8{q.vya[31]}}, q.vya};
        default: base = {{8{q.vyb[31]}}, q.vyb};
      endcase
      vel_nxt[j] = sat32($signed(j % 2 == 1 ? base + sd : base - sd));
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < 4; j++) vel_r[j] <= vel_nxt[j];
    end
  end

  // ---------------- sideband carried along the pipe ----------------
  always_comb begin
    p_nxt[0]         = '0;
    p_nxt[0].xa      = in_ch.pos_x_a;
    p_nxt[0].ya      = in_ch.pos_y_a;
    p_nxt[0].xb      = in_ch.pos_x_b;
    p_nxt[0].yb      = in_ch.pos_y_b;
    p_nxt[0].vxa     = in_ch.vel_x_a;
    p_nxt[0].vya     = in_ch.vel_y_a;
    p_nxt[0].vxb     = in_ch.vel_x_b;
    p_nxt[0].vyb     = in_ch.vel_y_b;
    p_nxt[0].ma      = in_ch.mass_a;
    p_nxt[0].mb      = in_ch.mass_b;
    p_nxt[0].msum    = {1'b0, in_ch.mass_a} + {1'b0, in_ch.mass_b};
    p_nxt[0].rsum    = {1'b0, in_ch.radius_a} + {1'b0, in_ch.radius_b};
    p_nxt[0].dx      = {in_ch.pos_x_b[31], in_ch.pos_x_b} - {in_ch.pos_x_a[31], in_ch.pos_x_a};
    p_nxt[0].dy      = {in_ch.pos_y_b[31], in_ch.pos_y_b} - {in_ch.pos_y_a[31], in_ch.pos_y_a};
    for (int s = 1; s < N_ST; s++) p_nxt[s] = p_r[s-1];
    p_nxt[2].contact = dist2 <= {2'b00, s1_rr_r};
    p_nxt[2].coinc   = (p_r[1].dx == '0) && (p_r[1].dy == '0);
    p_nxt[ST_SAT].nxb = sat32($signed(sep_x));
    p_nxt[ST_SAT].nyb = sat32($signed(sep_y));
    p_nxt[ST_E].exm    = mag33(ex);
    p_nxt[ST_E].eym    = mag33(ey);
    p_nxt[ST_E].ex_neg = ex[32];
    p_nxt[ST_E].ey_neg = ey[32];
    p_nxt[ST_DOT].dneg   = dm[66];
    p_nxt[ST_DOT].vel_ok = (len2 != '0) && (p_r[ST_DOT-1].msum != '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[N_ST-2:0], in_ch.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int s = 0; s < N_ST; s++) p_r[s] <= p_nxt[s];
    end
  end

  // ---------------- result select and output register ----------------
  logic [STAT_W-1:0]  out_status_r;
  logic signed [31:0] out_px_r, out_py_r;
  logic signed [31:0] out_vel_r [4];
  logic               use_new;
  dcr_pass_t          fin;

  assign fin     = p_r[N_ST-1];
  assign use_new = fin.contact && !fin.coinc && fin.vel_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv && v_r[N_ST-1]) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && v_r[N_ST-1]) begin
      if (!fin.contact) begin
        out_status_r <= STAT_NONE;
        out_px_r     <= fin.xb;
        out_py_r     <= fin.yb;
      end else if (fin.coinc) begin
        out_status_r <= STAT_COINC;
        out_px_r     <= fin.xa;
        out_py_r     <= fin.ya;
      end else begin
        out_status_r <= STAT_HIT;
        out_px_r     <= fin.nxb;
        out_py_r     <= fin.nyb;
      end
      out_vel_r[0] <= use_new ? vel_r[0] : fin.vxa;
      out_vel_r[1] <= use_new ? vel_r[1] : fin.vxb;
      out_vel_r[2] <= use_new ? vel_r[2] : fin.vya;
      out_vel_r[3] <= use_new ? vel_r[3] : fin.vyb;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.new_pos_x_b = out_px_r;
  assign out_ch.new_pos_y_b = out_py_r;
  assign out_ch.new_vel_x_a = out_vel_r[0];
  assign out_ch.new_vel_x_b = out_vel_r[1];
  assign out_ch.new_vel_y_a = out_vel_r[2];
  assign out_ch.new_vel_y_b = out_vel_r[3];

  // ---------------- checks ----------------
  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> v_r[0])
    else $error("accepted beat did not enter the pipe");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(v_r))
    else $error("pipe moved while stalled");

  a_coinc: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[N_ST-1] && fin.coinc) |-> fin.contact)
    else $error("coincident centers without contact");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && v_r[N_ST-1]) |=> out_valid_r)
    else $error("finished beat lost at output register");

endmodule
